/* rtl/gshs_pkg.sv */
// ----------------------------------------------------------------------------
// gshs_pkg: shared types, constants and arithmetic helpers
// Fixed-point widths, queue entry and status types, back-end states and the
// floored product and clamp functions used by the front and back ends.
// ----------------------------------------------------------------------------
package gshs_pkg;

  // Number of fraction bits in every fixed-point value.
  localparam int FRAC_BITS = 30;
  // Operand and coefficient width (Q1.30).
  localparam int OP_W = 32;
  // Width of a floored product and of c and d.
  localparam int PC_W = 35;
  // Width of a clamped derivative bracket.
  localparam int T_W = 34;
  // Width of a derivative result.
  localparam int DER_W = 37;
  // Width of the power index and of the order.
  localparam int IDX_W = 6;
  // Width of a bracket scaled by the power index.
  localparam int SC_W = T_W + IDX_W + 1;

  // Fixed-point 1.0.
  localparam logic signed [OP_W-1:0] ONE = OP_W'(1) << FRAC_BITS;

  // Depth of the queue between front and back end.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One prepared item as it waits between the two ends.
  typedef struct packed {
    logic signed [OP_W-1:0] k;
    logic signed [OP_W-1:0] h;
    logic signed [OP_W-1:0] alpha;
    logic signed [OP_W-1:0] beta;
    logic signed [PC_W-1:0] c;
    logic signed [PC_W-1:0] d;
  } op_t;

  // Fill status of the queue.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_SUM
  } back_state_t;

  // Exact product floored to FRAC_BITS fraction bits. The operands in use
  // never bring the result near the clamp limit, so no clamp is needed.
  function automatic logic signed [PC_W-1:0] mul_q(input logic signed [PC_W-1:0] a,
                                                  input logic signed [OP_W-1:0] b);
    logic signed [PC_W+OP_W-1:0] p;
    p = a * b;
    return p[FRAC_BITS+PC_W-1:FRAC_BITS];
  endfunction

  // Clamp a coefficient sum to +-1.0.
  function automatic logic signed [OP_W-1:0] sat_one(input logic signed [PC_W:0] v);
    logic signed [PC_W:0] lim;
    logic signed [PC_W:0] r;
    lim = (PC_W+1)'(ONE);
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r[OP_W-1:0];
  endfunction

  // Clamp a derivative bracket to +-limit. The result is never larger in
  // magnitude than the bracket itself, so it fits T_W bits.
  function automatic logic signed [T_W-1:0] clamp_t(input logic signed [PC_W:0] v,
                                                    input logic signed [DER_W-1:0] lim);
    logic signed [DER_W-1:0] ve;
    logic signed [DER_W-1:0] r;
    ve = DER_W'(v);
    if (ve > lim) begin
      r = lim;
    end else if (ve < -lim) begin
      r = -lim;
    end else begin
      r = ve;
    end
    return r[T_W-1:0];
  endfunction

  // Scale a clamped bracket by the power index and clamp again.
  function automatic logic signed [DER_W-1:0] scale_d(input logic signed [T_W-1:0] t,
                                                      input logic [IDX_W-1:0] s,
                                                      input logic signed [DER_W-1:0] lim);
    logic signed [SC_W-1:0] p;
    logic signed [SC_W-1:0] le;
    logic signed [SC_W-1:0] r;
    p = SC_W'(t) * SC_W'($signed({1'b0, s}));
    le = SC_W'(lim);
    if (p > le) begin
      r = le;
    end else if (p < -le) begin
      r = -le;
    end else begin
      r = p;
    end
    return r[DER_W-1:0];
  endfunction

endpackage

/* rtl/gshs_front.sv */
// ----------------------------------------------------------------------------
// gshs_front: input stage
// Accepts orbit quantities, registers the four operand products and forms
// c and d as the item is pushed into the queue.
// ----------------------------------------------------------------------------
module gshs_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic signed [gshs_pkg::OP_W-1:0] ecc_k,
  input  logic signed [gshs_pkg::OP_W-1:0] ecc_h,
  input  logic signed [gshs_pkg::OP_W-1:0] dir_alpha,
  input  logic signed [gshs_pkg::OP_W-1:0] dir_beta,
  output logic                          push,
  output gshs_pkg::op_t                 push_data,
  input  gshs_pkg::q_status_t           q_status
);
  import gshs_pkg::*;

  logic                   a_valid;
  logic                   a_valid_next;
  logic                   accept;
  logic signed [OP_W-1:0] a_k;
  logic signed [OP_W-1:0] a_h;
  logic signed [OP_W-1:0] a_alpha;
  logic signed [OP_W-1:0] a_beta;
  logic signed [PC_W-1:0] p_ka;
  logic signed [PC_W-1:0] p_hb;
  logic signed [PC_W-1:0] p_ha;
  logic signed [PC_W-1:0] p_kb;

  // The stage holds while the queue is full.
  assign item_stall   = a_valid && q_status.full;
  assign accept       = item_valid && !item_stall;
  assign push         = a_valid && !q_status.full;
  assign a_valid_next = accept || (a_valid && !push);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= a_valid_next;
    end
  end

  // Operands and their floored products are captured on each transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_k     <= ecc_k;
      a_h     <= ecc_h;
      a_alpha <= dir_alpha;
      a_beta  <= dir_beta;
      p_ka    <= mul_q(PC_W'(ecc_k), dir_alpha);
      p_hb    <= mul_q(PC_W'(ecc_h), dir_beta);
      p_ha    <= mul_q(PC_W'(ecc_h), dir_alpha);
      p_kb    <= mul_q(PC_W'(ecc_k), dir_beta);
    end
  end

  // c and d fit in the product width, so the sums need no extra bit.
  always_comb begin
    push_data.k     = a_k;
    push_data.h     = a_h;
    push_data.alpha = a_alpha;
    push_data.beta  = a_beta;
    push_data.c     = p_ka + p_hb;
    push_data.d     = p_ha - p_kb;
  end

endmodule

/* rtl/gshs_queue.sv */
// ----------------------------------------------------------------------------
// gshs_queue: short queue between front and back end
// Holds prepared items so that each end can stall on its own.
// ----------------------------------------------------------------------------
module gshs_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  gshs_pkg::op_t       wr_data,
  input  logic                pop,
  output gshs_pkg::op_t       rd_data,
  output gshs_pkg::q_status_t status
);
  import gshs_pkg::*;

  op_t                entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign status.full  = (count == Q_CNT_W'(Q_DEPTH));
  assign status.empty = (count == '0);
  assign rd_data      = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue fill count beyond depth");

endmodule

/* rtl/gshs_back.sv */
// ----------------------------------------------------------------------------
// gshs_back: power series sequencer
// Runs the recurrence for one item at a time, a multiply and a sum step per
// power, and scales the derivative brackets as the next power is multiplied.
// ----------------------------------------------------------------------------
module gshs_back #(
  parameter int MAX_ORDER = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [gshs_pkg::IDX_W-1:0]      series_order,
  input  gshs_pkg::op_t                   q_data,
  input  gshs_pkg::q_status_t             q_status,
  output logic                            pop,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [gshs_pkg::IDX_W-1:0]      power_index,
  output logic signed [gshs_pkg::OP_W-1:0]  g_coef,
  output logic signed [gshs_pkg::OP_W-1:0]  h_coef,
  output logic signed [gshs_pkg::DER_W-1:0] dg_by_h,
  output logic signed [gshs_pkg::DER_W-1:0] dg_by_k,
  output logic signed [gshs_pkg::DER_W-1:0] dg_by_alpha,
  output logic signed [gshs_pkg::DER_W-1:0] dg_by_beta,
  output logic                            run_last
);
  import gshs_pkg::*;

  back_state_t             state;
  back_state_t             state_next;
  logic                    pend;
  logic                    pend_next;
  logic                    slot_free;
  logic                    emit_go;
  logic                    load_go;
  logic                    mul_go;
  logic                    sum_go;
  logic [IDX_W-1:0]        ord_eff;

  // Current item.
  logic signed [OP_W-1:0]  k;
  logic signed [OP_W-1:0]  h;
  logic signed [OP_W-1:0]  alpha;
  logic signed [OP_W-1:0]  beta;
  logic signed [PC_W-1:0]  c;
  logic signed [PC_W-1:0]  d;
  logic [IDX_W-1:0]        ord_r;
  logic signed [DER_W-1:0] dlim;

  // Recurrence state and power counters.
  logic signed [OP_W-1:0]  g;
  logic signed [OP_W-1:0]  hh;
  logic [IDX_W-1:0]        s;
  logic [IDX_W-1:0]        s_emit;

  // Registered products.
  logic signed [PC_W-1:0]  p_cg;
  logic signed [PC_W-1:0]  p_dh;
  logic signed [PC_W-1:0]  p_dg;
  logic signed [PC_W-1:0]  p_ch;
  logic signed [PC_W-1:0]  p_bg;
  logic signed [PC_W-1:0]  p_ah;
  logic signed [PC_W-1:0]  p_ag;
  logic signed [PC_W-1:0]  p_bh;
  logic signed [PC_W-1:0]  p_kg;
  logic signed [PC_W-1:0]  p_hh;
  logic signed [PC_W-1:0]  p_hg;
  logic signed [PC_W-1:0]  p_kh;

  // Clamped derivative brackets waiting to be scaled.
  logic signed [T_W-1:0]   t_h;
  logic signed [T_W-1:0]   t_k;
  logic signed [T_W-1:0]   t_a;
  logic signed [T_W-1:0]   t_b;

  // An order of zero runs as one; anything above the maximum is capped.
  always_comb begin
    if (series_order == '0) begin
      ord_eff = IDX_W'(1);
    end else if (series_order > IDX_W'(MAX_ORDER)) begin
      ord_eff = IDX_W'(MAX_ORDER);
    end else begin
      ord_eff = series_order;
    end
  end

  assign dlim      = $signed(DER_W'(ord_r) << FRAC_BITS);
  assign slot_free = !result_valid || !result_stall;
  assign pop       = load_go;

  // Sequencer: next state and strobes.
  always_comb begin
    state_next = state;
    emit_go    = 1'b0;
    load_go    = 1'b0;
    mul_go     = 1'b0;
    sum_go     = 1'b0;
    case (state)
      B_IDLE: begin
        emit_go = pend && slot_free;
        load_go = !q_status.empty && (!pend || slot_free);
        if (load_go) begin
          state_next = B_MUL;
        end
      end
      B_MUL: begin
        emit_go = pend && slot_free;
        mul_go  = !pend || slot_free;
        if (mul_go) begin
          state_next = B_SUM;
        end
      end
      B_SUM: begin
        sum_go     = 1'b1;
        state_next = (s == ord_r) ? B_IDLE : B_MUL;
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
    pend_next = pend;
    if (emit_go) begin
      pend_next = 1'b0;
    end
    if (load_go || sum_go) begin
      pend_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      pend         <= pend_next;
      result_valid <= emit_go || (result_valid && result_stall);
    end
  end

  // Datapath: item load, products, sums and counters.
  always_ff @(posedge clk) begin
    if (load_go) begin
      k      <= q_data.k;
      h      <= q_data.h;
      alpha  <= q_data.alpha;
      beta   <= q_data.beta;
      c      <= q_data.c;
      d      <= q_data.d;
      ord_r  <= ord_eff;
      g      <= ONE;
      hh     <= '0;
      t_h    <= '0;
      t_k    <= '0;
      t_a    <= '0;
      t_b    <= '0;
      s_emit <= '0;
      s      <= IDX_W'(1);
    end
    if (mul_go) begin
      p_cg <= mul_q(c, g);
      p_dh <= mul_q(d, hh);
      p_dg <= mul_q(d, g);
      p_ch <= mul_q(c, hh);
      p_bg <= mul_q(PC_W'(beta), g);
      p_ah <= mul_q(PC_W'(alpha), hh);
      p_ag <= mul_q(PC_W'(alpha), g);
      p_bh <= mul_q(PC_W'(beta), hh);
      p_kg <= mul_q(PC_W'(k), g);
      p_hh <= mul_q(PC_W'(h), hh);
      p_hg <= mul_q(PC_W'(h), g);
      p_kh <= mul_q(PC_W'(k), hh);
    end
    if (sum_go) begin
      g      <= sat_one((PC_W+1)'(p_cg) - (PC_W+1)'(p_dh));
      hh     <= sat_one((PC_W+1)'(p_dg) + (PC_W+1)'(p_ch));
      t_h    <= clamp_t((PC_W+1)'(p_bg) - (PC_W+1)'(p_ah), dlim);
      t_k    <= clamp_t((PC_W+1)'(p_ag) + (PC_W+1)'(p_bh), dlim);
      t_a    <= clamp_t((PC_W+1)'(p_kg) - (PC_W+1)'(p_hh), dlim);
      t_b    <= clamp_t((PC_W+1)'(p_hg) + (PC_W+1)'(p_kh), dlim);
      s_emit <= s;
      s      <= s + 1'b1;
    end
  end

  // Output register: the pending power is scaled and presented.
  always_ff @(posedge clk) begin
    if (emit_go) begin
      power_index <= s_emit;
      g_coef      <= g;
      h_coef      <= hh;
      dg_by_h     <= scale_d(t_h, s_emit, dlim);
      dg_by_k     <= scale_d(t_k, s_emit, dlim);
      dg_by_alpha <= scale_d(t_a, s_emit, dlim);
      dg_by_beta  <= scale_d(t_b, s_emit, dlim);
      run_last    <= (s_emit == ord_r);
    end
  end

  a_sum_in_range: assert property (@(posedge clk) disable iff (rst)
    state == B_SUM |-> (s != '0 && s <= ord_r))
    else $error("power counter out of range in sum step");

  a_sum_sets_pending: assert property (@(posedge clk) disable iff (rst)
    state == B_SUM |=> pend)
    else $error("sum step left no pending result");

  a_coef_bounded: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (g_coef <= ONE && g_coef >= -ONE && h_coef <= ONE && h_coef >= -ONE))
    else $error("coefficient beyond unit range");

  a_zero_power: assert property (@(posedge clk) disable iff (rst)
    result_valid && power_index == '0 |->
      (dg_by_h == '0 && dg_by_k == '0 && dg_by_alpha == '0 && dg_by_beta == '0
       && g_coef == ONE && h_coef == '0))
    else $error("power zero result is not the unit term");

endmodule

/* rtl/gs_hs_power_series_with_gradients.sv */
// ----------------------------------------------------------------------------
// gs_hs_power_series_with_gradients: complex power series with gradients
// Forms c and d from orbit quantities and emits G_s, H_s and the partials
// of G_s for every power s from 0 to the configured order.
// ----------------------------------------------------------------------------
// Use of the block:
//   Input channel (item_valid / item_stall) takes k, h, alpha and beta in
//   signed Q1.30. A transfer happens on a rising edge with valid high and
//   stall low. Output channel (result_valid / result_stall) delivers one
//   result per power, s = 0 .. order, with run_last on the final one.
//   series_order sits at byte address 0 of the APB-style port; write it
//   only while the block is idle.
//   When the back end is free, an item goes through the front-end register,
//   the queue and the back-end item register, and its first result through
//   the output register. The back end then works on one item at a time,
//   with a multiply step and a clamping sum step per power of the recurrence.
//   A two-entry queue lets the front end take further items meanwhile.
//   Reset clears the queue, the sequencer and the output valid flag, and
//   sets the order to 8. While result_stall is high the result held is
//   kept and the sequencer waits; the front end keeps filling the queue.
// ----------------------------------------------------------------------------
module gs_hs_power_series_with_gradients #(
  parameter int MAX_ORDER = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // Input channel.
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic signed [gshs_pkg::OP_W-1:0]  ecc_k,
  input  logic signed [gshs_pkg::OP_W-1:0]  ecc_h,
  input  logic signed [gshs_pkg::OP_W-1:0]  dir_alpha,
  input  logic signed [gshs_pkg::OP_W-1:0]  dir_beta,
  // Output channel.
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [gshs_pkg::IDX_W-1:0]        power_index,
  output logic signed [gshs_pkg::OP_W-1:0]  g_coef,
  output logic signed [gshs_pkg::OP_W-1:0]  h_coef,
  output logic signed [gshs_pkg::DER_W-1:0] dg_by_h,
  output logic signed [gshs_pkg::DER_W-1:0] dg_by_k,
  output logic signed [gshs_pkg::DER_W-1:0] dg_by_alpha,
  output logic signed [gshs_pkg::DER_W-1:0] dg_by_beta,
  output logic                              run_last
);
  import gshs_pkg::*;

  localparam logic REG_ORDER = 1'b0;
  localparam logic [IDX_W-1:0] ORDER_RESET = IDX_W'(8);

  logic [IDX_W-1:0] series_order;
  logic             cfg_write;
  logic             q_push;
  logic             q_pop;
  op_t              q_wr_data;
  op_t              q_rd_data;
  q_status_t        q_status;

  // Configuration register: word index is address bit 2.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      series_order <= ORDER_RESET;
    end else if (cfg_write && paddr[2] == REG_ORDER) begin
      series_order <= pwdata[IDX_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ORDER) ? 32'(series_order) : '0;

  gshs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .ecc_k      (ecc_k),
    .ecc_h      (ecc_h),
    .dir_alpha  (dir_alpha),
    .dir_beta   (dir_beta),
    .push       (q_push),
    .push_data  (q_wr_data),
    .q_status   (q_status)
  );

  gshs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .status  (q_status)
  );

  gshs_back #(
    .MAX_ORDER (MAX_ORDER)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .series_order (series_order),
    .q_data       (q_rd_data),
    .q_status     (q_status),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .power_index  (power_index),
    .g_coef       (g_coef),
    .h_coef       (h_coef),
    .dg_by_h      (dg_by_h),
    .dg_by_k      (dg_by_k),
    .dg_by_alpha  (dg_by_alpha),
    .dg_by_beta   (dg_by_beta),
    .run_last     (run_last)
  );

endmodule

/* sim/gs_hs_power_series_with_gradients_tb.sv */
// ----------------------------------------------------------------------------
// gs_hs_power_series_with_gradients_tb: self-checking bench for the power series
// Drives orbit quantity sets into the block. For each transfer, a local
// fixed-point model works out every G_s, H_s and gradient term. Each result
// transfer is then compared field by field. It covers corner operands,
// order limits, random traffic under four idling mixes and a long receiver
// hold-off.
// ----------------------------------------------------------------------------
module gs_hs_power_series_with_gradients_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gshs_pkg::*;

  localparam int MAX_ORDER = 32;
  localparam logic [2:0] ADDR_SERIES_ORDER = 3'd0;
  localparam logic [5:0] ORDER_AT_RESET = 6'd8;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int END_SETTLE = 80;
  localparam logic signed [127:0] PROD_CLAMP = 128'sd1 <<< 61;

  // One set of orbit quantities as offered on the input channel.
  typedef struct packed {
    logic signed [OP_W-1:0] k;
    logic signed [OP_W-1:0] h;
    logic signed [OP_W-1:0] alpha;
    logic signed [OP_W-1:0] beta;
  } orbit_item_t;

  // One power term as delivered on the output channel.
  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [OP_W-1:0]  g;
    logic signed [OP_W-1:0]  h;
    logic signed [DER_W-1:0] dh;
    logic signed [DER_W-1:0] dk;
    logic signed [DER_W-1:0] da;
    logic signed [DER_W-1:0] db;
    logic                    last;
  } power_term_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic item_valid = 1'b0;
  logic item_stall;
  logic signed [OP_W-1:0] ecc_k = '0;
  logic signed [OP_W-1:0] ecc_h = '0;
  logic signed [OP_W-1:0] dir_alpha = '0;
  logic signed [OP_W-1:0] dir_beta = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [IDX_W-1:0] power_index;
  logic signed [OP_W-1:0] g_coef;
  logic signed [OP_W-1:0] h_coef;
  logic signed [DER_W-1:0] dg_by_h;
  logic signed [DER_W-1:0] dg_by_k;
  logic signed [DER_W-1:0] dg_by_alpha;
  logic signed [DER_W-1:0] dg_by_beta;
  logic run_last;

  // Predicted power terms, oldest first, and the order the block now uses.
  power_term_t pending_powers[$];
  logic [5:0] order_cfg = ORDER_AT_RESET;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  logic hold_toggle = 1'b0;
  logic hold_toggle_seen = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int settings_used = 0;

  gs_hs_power_series_with_gradients #(
    .MAX_ORDER(MAX_ORDER)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .ecc_k(ecc_k),
    .ecc_h(ecc_h),
    .dir_alpha(dir_alpha),
    .dir_beta(dir_beta),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .power_index(power_index),
    .g_coef(g_coef),
    .h_coef(h_coef),
    .dg_by_h(dg_by_h),
    .dg_by_k(dg_by_k),
    .dg_by_alpha(dg_by_alpha),
    .dg_by_beta(dg_by_beta),
    .run_last(run_last)
  );

  always #4 clk = ~clk;

  // Exact product, floored to the fraction width and clamped to +-2^61.
  function automatic longint floor_mul_q(input longint a, input longint b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] p;
    wa = a;
    wb = b;
    p = (wa * wb) >>> FRAC_BITS;
    if (p > PROD_CLAMP) begin
      p = PROD_CLAMP;
    end else if (p < -PROD_CLAMP) begin
      p = -PROD_CLAMP;
    end
    return p[63:0];
  endfunction

  function automatic longint clamp_to(input longint v, input longint lim);
    if (v > lim) begin
      return lim;
    end
    if (v < -lim) begin
      return -lim;
    end
    return v;
  endfunction

  // Works out every power term of one accepted item and queues them.
  task automatic predict_powers(input orbit_item_t it);
    longint k;
    longint h;
    longint al;
    longint be;
    longint ord;
    longint one;
    longint dlim;
    longint c;
    longint d;
    longint g;
    longint hh;
    longint ng;
    longint nh;
    longint s;
    longint dh;
    longint dk;
    longint da;
    longint db;
    power_term_t term;
    k = it.k;
    h = it.h;
    al = it.alpha;
    be = it.beta;
    ord = order_cfg;
    // An order of zero runs as one; anything above the maximum runs as the maximum.
    if (ord < 1) begin
      ord = 1;
    end
    if (ord > MAX_ORDER) begin
      ord = MAX_ORDER;
    end
    one = longint'(1) << FRAC_BITS;
    dlim = ord * one;
    c = floor_mul_q(k, al) + floor_mul_q(h, be);
    d = floor_mul_q(h, al) - floor_mul_q(k, be);
    g = one;
    hh = 0;
    for (s = 0; s <= ord; s++) begin
      dh = 0;
      dk = 0;
      da = 0;
      db = 0;
      if (s > 0) begin
        // The gradients use the previous, already clamped, G and H.
        ng = clamp_to(floor_mul_q(c, g) - floor_mul_q(d, hh), one);
        nh = clamp_to(floor_mul_q(d, g) + floor_mul_q(c, hh), one);
        dh = clamp_to(clamp_to(floor_mul_q(be, g) - floor_mul_q(al, hh), dlim) * s, dlim);
        dk = clamp_to(clamp_to(floor_mul_q(al, g) + floor_mul_q(be, hh), dlim) * s, dlim);
        da = clamp_to(clamp_to(floor_mul_q(k, g) - floor_mul_q(h, hh), dlim) * s, dlim);
        db = clamp_to(clamp_to(floor_mul_q(h, g) + floor_mul_q(k, hh), dlim) * s, dlim);
        g = ng;
        hh = nh;
      end
      term.idx = s[IDX_W-1:0];
      term.g = g[OP_W-1:0];
      term.h = hh[OP_W-1:0];
      term.dh = dh[DER_W-1:0];
      term.dk = dk[DER_W-1:0];
      term.da = da[DER_W-1:0];
      term.db = db[DER_W-1:0];
      term.last = (s == ord);
      pending_powers.push_back(term);
    end
  endtask

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Offers one item after a random idle gap and waits for its transfer.
  // The valid line is left high, so the caller must offer the next item or
  // drain in the same time step.
  task automatic send_item(input orbit_item_t it);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    item_valid <= 1'b1;
    ecc_k <= it.k;
    ecc_h <= it.h;
    dir_alpha <= it.alpha;
    dir_beta <= it.beta;
    do @(posedge clk); while (item_stall);
    predict_powers(it);
    items_sent++;
  endtask

  // Stops offering and waits until every predicted term has come back.
  task automatic drain_results();
    item_valid <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_order(input logic [5:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_SERIES_ORDER;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    order_cfg = value;
    settings_used++;
  endtask

  task automatic check_order_readback();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_SERIES_ORDER;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(order_cfg)) begin
      errors++;
      $display("%0t: series_order readback mismatch, expected %0d, got %0d",
               $time, order_cfg, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic signed [OP_W-1:0] random_operand();
    int unsigned pick;
    logic signed [OP_W-1:0] v;
    pick = $urandom_range(99);
    if (pick < 10) begin
      // Any bit pattern, well outside the stated range at times.
      v = $urandom;
    end else if (pick < 22) begin
      case ($urandom_range(4))
        0: v = ONE;
        1: v = -ONE;
        2: v = '0;
        3: v = 32'sh7FFF_FFFF;
        default: v = 32'sh8000_0000;
      endcase
    end else begin
      // In range, often scaled down so that the series decays instead of saturating.
      v = $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
      v = v >>> $urandom_range(4);
    end
    return v;
  endfunction

  function automatic orbit_item_t random_item();
    orbit_item_t it;
    it.k = random_operand();
    it.h = random_operand();
    it.alpha = random_operand();
    it.beta = random_operand();
    return it;
  endfunction

  // Corner operands, shared by the directed tests.
  orbit_item_t corners[10];

  // Corner operands at the order set by reset.
  task automatic test_corner_items();
    check_order_readback();
    for (int i = 0; i < 10; i++) begin
      send_item(corners[i]);
    end
    drain_results();
  endtask

  // Order of zero, one, the maximum and values past it.
  task automatic test_order_limits();
    logic [5:0] orders[5];
    orders = '{6'd0, 6'd1, 6'd32, 6'd63, 6'd33};
    for (int i = 0; i < 5; i++) begin
      write_order(orders[i]);
      check_order_readback();
      send_item(corners[1]);
      send_item(corners[4]);
      send_item(corners[5]);
      drain_results();
    end
  endtask

  // Random items under each idling mix, two order settings per mix.
  task automatic test_random_traffic();
    int unsigned tx_mix[4];
    int unsigned rx_mix[4];
    int unsigned r;
    tx_mix = '{0, 60, 0, 34};
    rx_mix = '{0, 0, 60, 34};
    for (int m = 0; m < 4; m++) begin
      for (int p = 0; p < 2; p++) begin
        r = $urandom_range(99);
        if (r < 75) begin
          write_order(6'($urandom_range(12, 1)));
        end else if (r < 90) begin
          write_order(6'($urandom_range(63, 13)));
        end else begin
          write_order(6'd0);
        end
        tx_idle_pct = tx_mix[m];
        rx_stall_pct = rx_mix[m];
        for (int i = 0; i < 40; i++) begin
          send_item(random_item());
        end
        drain_results();
      end
    end
    tx_idle_pct = 0;
    rx_stall_pct = 0;
  endtask

  // The receiver holds off while the sender keeps offering, so the block
  // fills up and stalls its input.
  task automatic test_receiver_hold_off();
    write_order(6'd6);
    hold_toggle <= ~hold_toggle;
    for (int i = 0; i < 30; i++) begin
      send_item(random_item());
    end
    drain_results();
  endtask

  // Output side: check each result transfer and drive the stall line.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_checked++;
        if (pending_powers.size() == 0) begin
          errors++;
          $display("%0t: result transfer with nothing predicted, power_index %0d",
                   $time, power_index);
        end else begin
          compare_field("power_index", pending_powers[0].idx, power_index);
          compare_field("g_coef", pending_powers[0].g, g_coef);
          compare_field("h_coef", pending_powers[0].h, h_coef);
          compare_field("dg_by_h", pending_powers[0].dh, dg_by_h);
          compare_field("dg_by_k", pending_powers[0].dk, dg_by_k);
          compare_field("dg_by_alpha", pending_powers[0].da, dg_by_alpha);
          compare_field("dg_by_beta", pending_powers[0].db, dg_by_beta);
          compare_field("run_last", pending_powers[0].last, run_last);
          void'(pending_powers.pop_front());
        end
      end
      if (hold_toggle != hold_toggle_seen) begin
        hold_toggle_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d terms still awaited",
               $time, quiet_cycles, pending_powers.size());
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    corners = '{
      '{32'sd0, 32'sd0, 32'sd0, 32'sd0},
      '{ONE, ONE, ONE, ONE},
      '{-ONE, -ONE, -ONE, -ONE},
      '{ONE, 32'sd0, ONE, 32'sd0},
      '{32'sd0, ONE, ONE, 32'sd0},
      '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF},
      '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000},
      '{32'sd3, -32'sd5, -32'sd7, 32'sd11},
      '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF},
      '{ONE >>> 1, ONE >>> 1, ONE >>> 1, -(ONE >>> 1)}
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_items();
    test_order_limits();
    test_random_traffic();
    test_receiver_hold_off();

    repeat (END_SETTLE) @(posedge clk);
    if (pending_powers.size() != 0) begin
      errors++;
      $display("%0t: %0d predicted terms never arrived", $time, pending_powers.size());
    end
    $display("Ran %0d items over %0d order settings, %0d power terms compared.",
             items_sent, settings_used + 1, results_checked);
    $display("Phases: corner operands, order limits, four idling mixes, long hold-off.");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
